// File: rtl/can_latest_frame_table_assert.svh
// Assertion macros for the checker file of the latest-frame table.
`ifndef CAN_LATEST_FRAME_TABLE_ASSERT_SVH
`define CAN_LATEST_FRAME_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLFT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clft assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CLFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clft assertion failed");

`endif

// File: rtl/clft_pkg.sv
// Package with constants, types and helper functions of the latest-frame table.
`timescale 1ns / 1ps
package clft_pkg;

  // Table geometry.
  localparam int SLOTS     = 32;
  localparam int MAP_BYTES = 256;
  localparam int ID_LIMIT  = MAP_BYTES * 8;
  localparam int MAX_BYTES = 8;
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W     = $clog2(SLOTS + 1);

  // Field widths of the channels.
  localparam int KIND_W  = 2;
  localparam int ID_W    = 29;
  localparam int DATA_W  = MAX_BYTES * 8;
  localparam int LEN_W   = 4;
  localparam int SLOT_W  = 5;
  localparam int COUNT_W = 6;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_CMP,
    ST_RDWAIT,
    ST_FINISH
  } state_t;

  // One table entry as stored in the RAM.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              id_ok;
    logic [SLOT_W-1:0] read_slot;
    logic              match;
    logic              in_fire;
    logic              out_free;
  } ctrl_stat_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic             in_ready;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             fin_load;
    logic             accepted;
    logic             slot_valid;
    logic [CNT_W-1:0] count;
  } ctrl_cmd_t;

  // Byte counts above the frame size store as a full frame.
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] n);
    return (n > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : n;
  endfunction

  // Replace the low len bytes of the old payload with those of the new one.
  function automatic logic [DATA_W-1:0] merge_payload(input logic [DATA_W-1:0] old_data,
                                                      input logic [DATA_W-1:0] new_data,
                                                      input logic [LEN_W-1:0]  len);
    logic [DATA_W-1:0] res;
    for (int b = 0; b < MAX_BYTES; b++) begin
      res[8*b +: 8] = (LEN_W'(b) < len) ? new_data[8*b +: 8] : old_data[8*b +: 8];
    end
    return res;
  endfunction

endpackage

// File: rtl/clft_ifs.sv
// Channel interfaces for requests into and results out of the latest-frame table.
`timescale 1ns / 1ps

interface clft_in_if
  import clft_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   frame_id;
  logic [DATA_W-1:0] payload;
  logic [LEN_W-1:0]  byte_count;
  logic [SLOT_W-1:0] read_slot;

  modport source (output valid, kind, frame_id, payload, byte_count, read_slot,
                  input ready);
  modport sink (input valid, kind, frame_id, payload, byte_count, read_slot,
                output ready);
endinterface

interface clft_out_if
  import clft_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [COUNT_W-1:0] stored_count;
  logic               slot_valid;
  logic [ID_W-1:0]    slot_id;
  logic [DATA_W-1:0]  slot_payload;
  logic [LEN_W-1:0]   slot_bytes;

  modport source (output valid, accepted, stored_count, slot_valid, slot_id,
                  slot_payload, slot_bytes, input ready);
  modport sink (input valid, accepted, stored_count, slot_valid, slot_id,
                slot_payload, slot_bytes, output ready);
endinterface

// File: rtl/clft_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module clft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/clft_ctrl.sv
// Sequencer that walks the table with the shared identifier comparator.
`timescale 1ns / 1ps
module clft_ctrl import clft_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  localparam int CMP_W = SLOT_W + CNT_W;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic             acc_r, acc_nxt;
  logic             vld_r, vld_nxt;
  logic             at_end;
  logic             full;

  assign at_end = (idx_r == occ_r);
  assign full   = (occ_r == CNT_W'(SLOTS));

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      occ_r   <= '0;
      acc_r   <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      occ_r   <= occ_nxt;
      acc_r   <= acc_nxt;
      vld_r   <= vld_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (stat.in_fire) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (stat.kind)
          KIND_APPEND: state_nxt = stat.id_ok ? ST_READ : ST_FINISH;
          KIND_READ:   state_nxt = ST_RDWAIT;
          default:     state_nxt = ST_FINISH;
        endcase
      end
      ST_READ: begin
        state_nxt = (at_end && full) ? ST_FINISH : ST_CMP;
      end
      ST_CMP: begin
        state_nxt = (at_end || stat.match) ? ST_FINISH : ST_READ;
      end
      ST_RDWAIT: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and register updates.
  always_comb begin
    cmd            = '0;
    cmd.rd_addr    = idx_r[IDX_W-1:0];
    cmd.wr_addr    = idx_r[IDX_W-1:0];
    cmd.count      = occ_r;
    cmd.accepted   = acc_r;
    cmd.slot_valid = vld_r;
    idx_nxt        = idx_r;
    occ_nxt        = occ_r;
    acc_nxt        = acc_r;
    vld_nxt        = vld_r;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
      end
      ST_DISPATCH: begin
        acc_nxt = 1'b0;
        vld_nxt = 1'b0;
        idx_nxt = '0;
        case (stat.kind)
          KIND_CLEAR: begin
            occ_nxt = '0;
          end
          KIND_READ: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = stat.read_slot[IDX_W-1:0];
            vld_nxt     = (CMP_W'(stat.read_slot) < CMP_W'(occ_r));
          end
          default: ;
        endcase
      end
      ST_READ: begin
        // Fetch the entry under test, or the free slot's old bytes at the end.
        cmd.rd_en = !(at_end && full);
      end
      ST_CMP: begin
        if (at_end || stat.match) begin
          cmd.wr_en = 1'b1;
          acc_nxt   = 1'b1;
          if (at_end) occ_nxt = occ_r + CNT_W'(1);
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_FINISH: begin
        cmd.fin_load = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/can_latest_frame_table.sv
// Requests are handled one at a time; the next is taken the cycle after the result is loaded.
// Reset: synchronous, active low; the table count and handshakes clear, entries do not.
// The search reads each stored identifier and then compares it, one slot after another.
`timescale 1ns / 1ps
module can_latest_frame_table import clft_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  clft_in_if.sink   in_chan,
  clft_out_if.source out_chan
);

  // Captured request.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   frame_id;
    logic [DATA_W-1:0] payload;
    logic [LEN_W-1:0]  byte_count;
    logic [SLOT_W-1:0] read_slot;
  } req_t;

  req_t               req_r;
  ctrl_stat_t         stat;
  ctrl_cmd_t          cmd;
  entry_t             rd_entry;
  entry_t             wr_entry;
  logic [ENTRY_W-1:0] rd_data;
  logic [LEN_W-1:0]   len_sat;
  logic               in_fire;
  logic               out_valid_r;
  logic               out_acc_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_svld_r;
  logic [ID_W-1:0]    out_id_r;
  logic [DATA_W-1:0]  out_data_r;
  logic [LEN_W-1:0]   out_len_r;

  assign in_fire       = in_chan.valid && cmd.in_ready;
  assign in_chan.ready = cmd.in_ready;

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.kind       <= in_chan.kind;
      req_r.frame_id   <= in_chan.frame_id;
      req_r.payload    <= in_chan.payload;
      req_r.byte_count <= in_chan.byte_count;
      req_r.read_slot  <= in_chan.read_slot;
    end
  end

  // Entry storage.
  clft_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(cmd.wr_addr),
    .wr_data(wr_entry),
    .rd_en  (cmd.rd_en),
    .rd_addr(cmd.rd_addr),
    .rd_data(rd_data)
  );

  assign rd_entry = entry_t'(rd_data);

  // New entry contents merged with the bytes already held in the slot.
  assign len_sat          = sat_len(req_r.byte_count);
  assign wr_entry.id      = req_r.frame_id;
  assign wr_entry.len     = len_sat;
  assign wr_entry.payload = merge_payload(rd_entry.payload, req_r.payload, len_sat);

  // Status for the sequencer, including the shared identifier compare.
  assign stat.kind      = req_r.kind;
  assign stat.id_ok     = (req_r.frame_id < ID_W'(ID_LIMIT));
  assign stat.read_slot = req_r.read_slot;
  assign stat.match     = (rd_entry.id == req_r.frame_id);
  assign stat.in_fire   = in_fire;
  assign stat.out_free  = !out_valid_r || out_chan.ready;

  clft_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .cmd  (cmd)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_load) begin
      out_acc_r   <= cmd.accepted;
      out_count_r <= COUNT_W'(cmd.count);
      out_svld_r  <= cmd.slot_valid;
      out_id_r    <= cmd.slot_valid ? rd_entry.id : '0;
      out_data_r  <= cmd.slot_valid ? rd_entry.payload : '0;
      out_len_r   <= cmd.slot_valid ? rd_entry.len : '0;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.accepted     = out_acc_r;
  assign out_chan.stored_count = out_count_r;
  assign out_chan.slot_valid   = out_svld_r;
  assign out_chan.slot_id      = out_id_r;
  assign out_chan.slot_payload = out_data_r;
  assign out_chan.slot_bytes   = out_len_r;

endmodule

// File: rtl/clft_chk.sv
// Port-level checker for the latest-frame table and its bind statement.
`timescale 1ns / 1ps
`include "can_latest_frame_table_assert.svh"
module clft_chk import clft_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               accepted,
  input logic [COUNT_W-1:0] stored_count,
  input logic               slot_valid,
  input logic [ID_W-1:0]    slot_id,
  input logic [DATA_W-1:0]  slot_payload,
  input logic [LEN_W-1:0]   slot_bytes
);

  // A result waiting for the sink stays offered.
  `CLFT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // The block works on one request at a time.
  `CLFT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

  // The count never passes the table size, and a stored frame leaves it nonzero.
  `CLFT_ASSERT_SAME(a_count_range, clk, rst_n, out_valid,
                    (stored_count <= COUNT_W'(SLOTS)) && (!accepted || (stored_count != '0)))

  // An append result and a valid read result never come together.
  `CLFT_ASSERT_SAME(a_excl_flags, clk, rst_n, out_valid, !(accepted && slot_valid))

  // Slot fields are zero unless a valid slot was read.
  `CLFT_ASSERT_SAME(a_zero_fields, clk, rst_n, out_valid && !slot_valid,
                    (slot_id == '0) && (slot_payload == '0) && (slot_bytes == '0))

endmodule

bind can_latest_frame_table clft_chk u_clft_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .accepted    (out_chan.accepted),
  .stored_count(out_chan.stored_count),
  .slot_valid  (out_chan.slot_valid),
  .slot_id     (out_chan.slot_id),
  .slot_payload(out_chan.slot_payload),
  .slot_bytes  (out_chan.slot_bytes)
);

// File: bench/can_latest_frame_table_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the latest-frame table, checked against a predictor of the table.
module can_latest_frame_table_tb;
  import clft_pkg::*;

  // The request code that the table does not define.
  localparam logic [KIND_W-1:0] KIND_UNDEF = 2'd3;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 2 * SLOTS + 40;
  localparam int RANDOM_REQS    = 750;
  localparam int ID_POOL        = 44;
  localparam int REPORT_MAX     = 10;
  localparam int HOLD_CYCLES    = 250;

  // One request as queued for the driver; pause_here marks a wait for all results.
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   frame_id;
    logic [DATA_W-1:0] payload;
    logic [LEN_W-1:0]  byte_count;
    logic [SLOT_W-1:0] read_slot;
    bit                pause_here;
  } frame_req_t;

  // One result of the table.
  typedef struct packed {
    logic               accepted;
    logic [COUNT_W-1:0] stored_count;
    logic               slot_valid;
    logic [ID_W-1:0]    slot_id;
    logic [DATA_W-1:0]  slot_payload;
    logic [LEN_W-1:0]   slot_bytes;
  } table_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  clft_in_if  in_if ();
  clft_out_if out_if ();

  can_latest_frame_table uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #4 clk = ~clk;

  frame_req_t    req_pending[$];
  table_result_t result_due[$];

  // Predicted table contents.
  logic [ID_LIMIT-1:0] id_present;
  logic [ID_W-1:0]     slot_ids  [SLOTS];
  logic [DATA_W-1:0]   slot_data [SLOTS];
  logic [LEN_W-1:0]    slot_len  [SLOTS];
  int                  slots_used;

  logic [ID_W-1:0] id_pool [ID_POOL];

  int miss_count   = 0;
  int req_taken    = 0;
  int results_seen = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  int holds_done   = 0;
  int idle_cycles  = 0;
  bit waiting_all  = 1'b0;
  frame_req_t    next_req;
  frame_req_t    taken_req;
  table_result_t seen_res;

  // Apply one request to the predicted table and return the result it must produce.
  function automatic table_result_t table_apply(frame_req_t r);
    table_result_t    res;
    logic [LEN_W-1:0] n;
    int               hit;
    res = '0;
    hit = -1;
    case (r.kind)
      KIND_APPEND: begin
        if (r.frame_id < ID_LIMIT) begin
          n = (r.byte_count > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : r.byte_count;
          if (id_present[r.frame_id]) begin
            // A known identifier overwrites its own slot.
            for (int i = 0; i < slots_used; i++) begin
              if (hit < 0 && slot_ids[i] == r.frame_id) hit = i;
            end
          end else if (slots_used < SLOTS) begin
            hit = slots_used;
            slots_used++;
          end
          if (hit >= 0) begin
            id_present[r.frame_id] = 1'b1;
            slot_ids[hit] = r.frame_id;
            for (int b = 0; b < MAX_BYTES; b++) begin
              if (b < n) slot_data[hit][8*b +: 8] = r.payload[8*b +: 8];
            end
            slot_len[hit] = n;
            res.accepted = 1'b1;
          end
        end
      end
      KIND_CLEAR: begin
        id_present = '0;
        slots_used = 0;
      end
      KIND_READ: begin
        if (r.read_slot < slots_used) begin
          res.slot_valid   = 1'b1;
          res.slot_id      = slot_ids[r.read_slot];
          res.slot_payload = slot_data[r.read_slot];
          res.slot_bytes   = slot_len[r.read_slot];
        end
      end
      default: ;
    endcase
    res.stored_count = COUNT_W'(slots_used);
    return res;
  endfunction

  function automatic void report_miss(string what, table_result_t want, table_result_t got);
    miss_count++;
    if (miss_count <= REPORT_MAX) begin
      $display("%0t: %s: expected acc=%0d cnt=%0d val=%0d id=%h data=%h len=%0d", $realtime,
               what, want.accepted, want.stored_count, want.slot_valid, want.slot_id,
               want.slot_payload, want.slot_bytes);
      $display("%0t: %s: actual   acc=%0d cnt=%0d val=%0d id=%h data=%h len=%0d", $realtime,
               what, got.accepted, got.stored_count, got.slot_valid, got.slot_id,
               got.slot_payload, got.slot_bytes);
    end
  endfunction

  // Compare a result with the oldest prediction, field by field.
  function automatic void check_result(table_result_t got);
    table_result_t want;
    if (result_due.size() == 0) begin
      report_miss("result with no request outstanding", '0, got);
    end else begin
      want = result_due.pop_front();
      if (got.accepted !== want.accepted || got.stored_count !== want.stored_count ||
          got.slot_valid !== want.slot_valid || got.slot_id !== want.slot_id ||
          got.slot_payload !== want.slot_payload || got.slot_bytes !== want.slot_bytes) begin
        report_miss("result mismatch", want, got);
      end
    end
  endfunction

  // Mostly no pause, some short pauses, a few long ones.
  function automatic int pick_pause();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Identifiers come mostly from a small pool, so overwrites and a full table are common.
  function automatic logic [ID_W-1:0] pick_id();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return id_pool[$urandom_range(0, ID_POOL - 1)];
    if (roll < 92) return ID_W'($urandom_range(0, ID_LIMIT - 1));
    if (roll < 97) return ID_W'($urandom_range(ID_LIMIT, (1 << ID_W) - 1));
    return ID_W'($urandom);
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return LEN_W'($urandom_range(0, MAX_BYTES));
    if (roll < 85) return LEN_W'(MAX_BYTES);
    return LEN_W'($urandom_range(MAX_BYTES + 1, (1 << LEN_W) - 1));
  endfunction

  // A request of the given kind with every field random.
  function automatic frame_req_t rand_req(logic [KIND_W-1:0] kind);
    frame_req_t r;
    r.kind       = kind;
    r.frame_id   = pick_id();
    r.payload    = {$urandom, $urandom};
    r.byte_count = pick_len();
    r.read_slot  = SLOT_W'($urandom_range(0, SLOTS - 1));
    r.pause_here = 1'b0;
    return r;
  endfunction

  function automatic void queue_req(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                    logic [DATA_W-1:0] data, logic [LEN_W-1:0] len,
                                    logic [SLOT_W-1:0] slot);
    frame_req_t r;
    r = '{kind, id, data, len, slot, 1'b0};
    req_pending.push_back(r);
  endfunction

  // Request driver: predicts each request as it is taken, then offers the next.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        taken_req = '{in_if.kind, in_if.frame_id, in_if.payload, in_if.byte_count,
                      in_if.read_slot, 1'b0};
        result_due.push_back(table_apply(taken_req));
        req_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (waiting_all) begin
          in_if.valid <= 1'b0;
          if (result_due.size() == 0) waiting_all = 1'b0;
        end else if (req_pending.size() > 0) begin
          next_req = req_pending.pop_front();
          if (next_req.pause_here) begin
            waiting_all = 1'b1;
            in_if.valid <= 1'b0;
          end else begin
            in_if.kind       <= next_req.kind;
            in_if.frame_id   <= next_req.frame_id;
            in_if.payload    <= next_req.payload;
            in_if.byte_count <= next_req.byte_count;
            in_if.read_slot  <= next_req.read_slot;
            in_if.valid      <= 1'b1;
            // Every fourth stretch of 64 requests goes without gaps.
            gap_left = (((req_taken / 64) % 4) == 1) ? 0 : pick_pause();
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result and stalls the output at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        seen_res = '{out_if.accepted, out_if.stored_count, out_if.slot_valid, out_if.slot_id,
                     out_if.slot_payload, out_if.slot_bytes};
        check_result(seen_res);
        results_seen <= results_seen + 1;
        stall_left = (((results_seen / 80) % 5) == 2) ? 0 : pick_pause();
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Long output hold-offs, so the table backs up into its request side.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && results_seen >= 150 + 300 * holds_done) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Watchdog on cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("can_latest_frame_table_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus, then wait for the table to drain and give the verdict.
  initial begin
    int         gen_count;
    int         ep_len;
    int         episode;
    int         roll;
    frame_req_t r;

    in_if.valid      = 1'b0;
    in_if.kind       = KIND_APPEND;
    in_if.frame_id   = '0;
    in_if.payload    = '0;
    in_if.byte_count = '0;
    in_if.read_slot  = '0;
    out_if.ready     = 1'b0;
    id_present       = '0;
    slots_used       = 0;

    id_pool[0] = '0;
    id_pool[1] = ID_W'(ID_LIMIT - 1);
    for (int i = 2; i < ID_POOL; i++) id_pool[i] = ID_W'($urandom_range(0, ID_LIMIT - 1));

    // Directed part. An empty table reads as invalid; an undefined code does nothing.
    queue_req(KIND_READ, '0, '0, '0, '0);
    queue_req(KIND_UNDEF, '1, '1, '1, '1);
    // Fill every slot with full frames, so no slot ever holds unwritten bytes.
    // Two fills use byte counts above eight, which saturate to a full frame.
    queue_req(KIND_APPEND, '0, '1, LEN_W'(MAX_BYTES), '0);
    queue_req(KIND_APPEND, ID_W'(ID_LIMIT - 1), '0, LEN_W'(MAX_BYTES), '0);
    queue_req(KIND_APPEND, ID_W'(100), {$urandom, $urandom}, '1, '0);
    queue_req(KIND_APPEND, ID_W'(101), {$urandom, $urandom}, LEN_W'(MAX_BYTES + 1), '0);
    for (int i = 4; i < SLOTS; i++) begin
      queue_req(KIND_APPEND, ID_W'(100 + i), {$urandom, $urandom}, LEN_W'(MAX_BYTES), '0);
    end
    // Out-of-range identifiers and a new identifier on a full table are rejected.
    queue_req(KIND_APPEND, ID_W'(ID_LIMIT), '1, LEN_W'(MAX_BYTES), '0);
    queue_req(KIND_APPEND, '1, '1, LEN_W'(MAX_BYTES), '0);
    queue_req(KIND_APPEND, ID_W'(5), '1, LEN_W'(MAX_BYTES), '0);
    // Overwrites with no bytes and with a partial frame keep the higher bytes.
    queue_req(KIND_APPEND, '0, '0, '0, '0);
    queue_req(KIND_APPEND, ID_W'(ID_LIMIT - 1), 64'h0123_4567_89ab_cdef, LEN_W'(3), '0);
    queue_req(KIND_READ, '0, '0, '0, '0);
    queue_req(KIND_READ, '0, '0, '0, SLOT_W'(1));
    queue_req(KIND_READ, '0, '0, '0, '1);
    // After a clear the count restarts while the old entries stay behind.
    queue_req(KIND_CLEAR, '0, '0, '0, '0);
    queue_req(KIND_READ, '0, '0, '0, '0);
    queue_req(KIND_APPEND, ID_W'(ID_LIMIT - 1), '1, LEN_W'(1), '0);
    queue_req(KIND_READ, '0, '0, '0, '0);
    queue_req(KIND_READ, '0, '0, '0, '1);

    // Random part: episodes of mostly appends and reads, with a few undefined codes and clears, each closed by a clear.
    gen_count = 0;
    episode   = 0;
    while (gen_count < RANDOM_REQS) begin
      ep_len = $urandom_range(10, 80);
      for (int k = 0; k < ep_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 63) r = rand_req(KIND_APPEND);
        else if (roll < 94) r = rand_req(KIND_READ);
        else if (roll < 97) r = rand_req(KIND_UNDEF);
        else r = rand_req(KIND_CLEAR);
        req_pending.push_back(r);
        if (r.kind != KIND_UNDEF) gen_count++;
      end
      req_pending.push_back(rand_req(KIND_CLEAR));
      gen_count++;
      episode++;
      // Now and then the sender waits until every result is back.
      if (episode == 3 || episode == 10) begin
        r = rand_req(KIND_READ);
        r.pause_here = 1'b1;
        req_pending.push_back(r);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (req_pending.size() != 0 || in_if.valid !== 1'b0 || result_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (miss_count == 0) begin
      $display("can_latest_frame_table_tb OK");
    end else begin
      $display("can_latest_frame_table_tb NOT OK");
    end
    $finish;
  end

endmodule
